/* rtl/gcd_pkg.sv */
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 30;
    localparam int CORDIC_STEPS    = 32;
    localparam int AW              = 36;
    localparam int MW              = 36;
    localparam int CCS_W           = 27;
    localparam int RADIUS_W        = 20;
    localparam int DIST_W          = 22;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);
    localparam int MCNT_W          = $clog2(MW + 1);

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_PER_CCS = PI_Q60 / 64'd64800000;
    localparam logic [63:0] GAIN_Q40    = 64'd667681663043;

    typedef logic signed [AW-1:0] ang_t;
    typedef ang_t atan_tbl_t [CORDIC_STEPS];

    localparam ang_t PI_Q = AW'((PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS)))
                                >> (60 - ANGLE_FRAC_BITS));
    localparam ang_t TWO_PI_Q = AW'(PI_Q <<< 1);
    localparam ang_t HALF_PI_Q = AW'((PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS)))
                                     >> (61 - ANGLE_FRAC_BITS));
    localparam ang_t GAIN_Q = AW'((GAIN_Q40 + (64'd1 << (39 - ANGLE_FRAC_BITS)))
                                  >> (40 - ANGLE_FRAC_BITS));
    localparam ang_t ONE_Q = AW'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic [2*MW-1:0] Q_HALF = (2*MW)'(1) << (ANGLE_FRAC_BITS - 1);

    localparam logic MODE_ROTATE = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    // shift-subtract quotient of non-negative operands below 2^63
    function automatic longint udiv(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (longint'(1) << b);
            end
        end
        return quo;
    endfunction

    function automatic atan_tbl_t build_atan();
        atan_tbl_t t;
        longint    sum;
        longint    term;
        int        e;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sum = 0;
            if (i == 0) begin
                sum = longint'(PI_Q60);
            end else begin
                for (int k = 0; k < 64; k++) begin
                    e = 62 - i * (2 * k + 1);
                    if (e >= 0) begin
                        term = udiv(longint'(1) << e, longint'(2 * k + 1));
                        sum = ((k & 1) == 1) ? sum - term : sum + term;
                    end
                end
            end
            t[i] = AW'((sum + (longint'(1) << (61 - ANGLE_FRAC_BITS)))
                       >>> (62 - ANGLE_FRAC_BITS));
        end
        return t;
    endfunction

    localparam atan_tbl_t ATAN_TBL = build_atan();

endpackage

/* rtl/gcd_mul.sv */
module gcd_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 go,
    input  logic [gcd_pkg::MW-1:0]   a,
    input  logic [gcd_pkg::MW-1:0]   b,
    output logic                 done,
    output logic [2*gcd_pkg::MW-1:0] p
);

    logic [2*gcd_pkg::MW-1:0]   prod_reg;
    logic [gcd_pkg::MW-1:0]     a_reg;
    logic [gcd_pkg::MCNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [gcd_pkg::MW:0]       sum;

    // one multiplier bit per cycle, product shifts right
    assign sum = {1'b0, prod_reg[2*gcd_pkg::MW-1:gcd_pkg::MW]}
               + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= gcd_pkg::MCNT_W'(gcd_pkg::MW);
                a_reg    <= a;
                prod_reg <= {{gcd_pkg::MW{1'b0}}, b};
            end else if (busy_reg) begin
                prod_reg <= {sum, prod_reg[gcd_pkg::MW-1:1]};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == gcd_pkg::MCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = prod_reg;

endmodule

/* rtl/gcd_cordic.sv */
module gcd_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  logic                mode,
    input  gcd_pkg::ang_t       x0,
    input  gcd_pkg::ang_t       y0,
    input  gcd_pkg::ang_t       z0,
    output logic                done,
    output gcd_pkg::ang_t       x,
    output gcd_pkg::ang_t       y,
    output gcd_pkg::ang_t       z
);

    gcd_pkg::ang_t              x_reg, y_reg, z_reg;
    gcd_pkg::ang_t              xs, ys, at;
    logic [gcd_pkg::STEP_W-1:0] i_reg;
    logic                       mode_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       pos;

    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    assign at  = gcd_pkg::ATAN_TBL[i_reg];
    assign pos = (mode_reg == gcd_pkg::MODE_ROTATE) ? !z_reg[gcd_pkg::AW-1]
                                                    : !(y_reg > 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                mode_reg <= mode;
                i_reg    <= '0;
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
            end else if (busy_reg) begin
                if (pos) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == gcd_pkg::STEP_W'(gcd_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

/* rtl/great_circle_distance.sv */
// A first point is converted to radians and stored, after which s_ready is high again; a
// second point runs through conversion, angle reduction (longer when the longitude difference
// needs it), rotations, products, the square root, a vectoring pass and the radius product,
// and its result waits while a held result is not yet accepted. One item is worked on at a
// time. Built on the shared bit-serial multiplier, the shared CORDIC unit and a square root.
// Synchronous active-low reset clears the stored first point to (0, 0), sets the
// radius to 6371.01 km and empties the result register.
module great_circle_distance (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [6:0]                    s_lat_degrees,
    input  logic [5:0]                    s_lat_minutes,
    input  logic [12:0]                   s_lat_centiseconds,
    input  logic                          s_lat_south,
    input  logic [7:0]                    s_lon_degrees,
    input  logic [5:0]                    s_lon_minutes,
    input  logic [12:0]                   s_lon_centiseconds,
    input  logic                          s_lon_west,
    input  logic                          s_is_second,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcd_pkg::DIST_W-1:0]    m_distance_centi_km
);

    localparam int AW  = gcd_pkg::AW;
    localparam int MW  = gcd_pkg::MW;
    localparam int AFB = gcd_pkg::ANGLE_FRAC_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CVT  = 4'd1;
    localparam logic [3:0] ST_RED  = 4'd2;
    localparam logic [3:0] ST_ROT  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_VEC  = 4'd6;
    localparam logic [3:0] ST_RAD  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]                     state_reg;
    logic [1:0]                     sel_reg;
    logic [gcd_pkg::CCS_W-1:0]      ccs_lon_reg;
    logic                           lon_neg_reg;
    logic                           lat_neg_reg;
    logic                           second_reg;
    gcd_pkg::ang_t                  lat_reg, lon_reg;
    gcd_pkg::ang_t                  first_lat_reg, first_lon_reg;
    gcd_pkg::ang_t                  ang_reg;
    logic                           fneg_reg;
    gcd_pkg::ang_t                  s1_reg, c1_reg, s2_reg, c2_reg, cd_reg;
    gcd_pkg::ang_t                  m1_reg, c_reg;
    logic                           pneg_reg;
    logic [gcd_pkg::RADIUS_W-1:0]   radius_reg;
    logic                           m_valid_reg;
    logic [gcd_pkg::DIST_W-1:0]     m_dist_reg;
    logic [63:0]                    rad_reg;
    logic [AW-1:0]                  rem_reg;
    logic [31:0]                    root_reg;
    logic [4:0]                     sq_cnt_reg;

    logic                           mul_go_reg;
    logic [MW-1:0]                  mul_a_reg, mul_b_reg;
    logic                           mul_done;
    logic [2*MW-1:0]                mul_p;
    logic                           cor_go_reg;
    logic                           cor_mode_reg;
    gcd_pkg::ang_t                  cor_x0_reg, cor_y0_reg, cor_z0_reg;
    logic                           cor_done;
    gcd_pkg::ang_t                  cor_x, cor_y, cor_z;

    logic [gcd_pkg::CCS_W-1:0]      ccs_lat, ccs_lon;
    logic [2*MW-1:0]                rnd;
    gcd_pkg::ang_t                  mag, qres, dot, c2v, theta, ang_fold;
    gcd_pkg::ang_t                  rot_s, rot_c;
    logic [AW-1:0]                  rem_sh, trial;
    logic                           fold_neg;

    function automatic logic [MW-1:0] absv(input gcd_pkg::ang_t v);
        return v[AW-1] ? MW'(-v) : MW'(v);
    endfunction

    gcd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .p       (mul_p)
    );

    gcd_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cor_go_reg),
        .mode    (cor_mode_reg),
        .x0      (cor_x0_reg),
        .y0      (cor_y0_reg),
        .z0      (cor_z0_reg),
        .done    (cor_done),
        .x       (cor_x),
        .y       (cor_y),
        .z       (cor_z)
    );

    assign ccs_lat = gcd_pkg::CCS_W'(s_lat_degrees) * gcd_pkg::CCS_W'(360000)
                   + gcd_pkg::CCS_W'(s_lat_minutes) * gcd_pkg::CCS_W'(6000)
                   + gcd_pkg::CCS_W'(s_lat_centiseconds);
    assign ccs_lon = gcd_pkg::CCS_W'(s_lon_degrees) * gcd_pkg::CCS_W'(360000)
                   + gcd_pkg::CCS_W'(s_lon_minutes) * gcd_pkg::CCS_W'(6000)
                   + gcd_pkg::CCS_W'(s_lon_centiseconds);

    assign rnd  = mul_p + gcd_pkg::Q_HALF;
    assign mag  = gcd_pkg::ang_t'(rnd[AFB +: AW]);
    assign qres = pneg_reg ? -mag : mag;
    assign dot  = m1_reg + qres;
    assign c2v  = (qres > gcd_pkg::ONE_Q) ? gcd_pkg::ONE_Q : qres;

    assign theta = cor_z[AW-1] ? '0 : ((cor_z > gcd_pkg::PI_Q) ? gcd_pkg::PI_Q : cor_z);

    assign rot_s = fneg_reg ? -cor_y : cor_y;
    assign rot_c = fneg_reg ? -cor_x : cor_x;

    always_comb begin
        fold_neg = 1'b1;
        if (ang_reg > gcd_pkg::HALF_PI_Q) begin
            ang_fold = ang_reg - gcd_pkg::PI_Q;
        end else if (ang_reg < -gcd_pkg::HALF_PI_Q) begin
            ang_fold = ang_reg + gcd_pkg::PI_Q;
        end else begin
            ang_fold = ang_reg;
            fold_neg = 1'b0;
        end
    end

    assign rem_sh = {rem_reg[AW-3:0], rad_reg[63:62]};
    assign trial  = {{(AW-34){1'b0}}, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sel_reg       <= '0;
            first_lat_reg <= '0;
            first_lon_reg <= '0;
            radius_reg    <= gcd_pkg::RADIUS_W'(637101);
            m_valid_reg   <= 1'b0;
            mul_go_reg    <= 1'b0;
            cor_go_reg    <= 1'b0;
        end else begin
            mul_go_reg <= 1'b0;
            cor_go_reg <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0) begin
                radius_reg <= pwdata[gcd_pkg::RADIUS_W-1:0];
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ccs_lon_reg <= ccs_lon;
                        lat_neg_reg <= s_lat_south;
                        lon_neg_reg <= s_lon_west;
                        second_reg  <= s_is_second;
                        mul_a_reg   <= MW'(ccs_lat);
                        mul_b_reg   <= MW'(gcd_pkg::RAD_PER_CCS);
                        mul_go_reg  <= 1'b1;
                        sel_reg     <= 2'd0;
                        state_reg   <= ST_CVT;
                    end
                end
                ST_CVT: begin
                    if (mul_done) begin
                        if (sel_reg == 2'd0) begin
                            lat_reg    <= lat_neg_reg ? -mag : mag;
                            mul_a_reg  <= MW'(ccs_lon_reg);
                            mul_go_reg <= 1'b1;
                            sel_reg    <= 2'd1;
                        end else if (!second_reg) begin
                            first_lat_reg <= lat_reg;
                            first_lon_reg <= lon_neg_reg ? -mag : mag;
                            state_reg     <= ST_IDLE;
                        end else begin
                            lon_reg   <= lon_neg_reg ? -mag : mag;
                            ang_reg   <= first_lat_reg;
                            sel_reg   <= 2'd0;
                            state_reg <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    if (ang_reg > gcd_pkg::PI_Q) begin
                        ang_reg <= ang_reg - gcd_pkg::TWO_PI_Q;
                    end else if (ang_reg <= -gcd_pkg::PI_Q) begin
                        ang_reg <= ang_reg + gcd_pkg::TWO_PI_Q;
                    end else begin
                        fneg_reg     <= fold_neg;
                        cor_x0_reg   <= gcd_pkg::GAIN_Q;
                        cor_y0_reg   <= '0;
                        cor_z0_reg   <= ang_fold;
                        cor_mode_reg <= gcd_pkg::MODE_ROTATE;
                        cor_go_reg   <= 1'b1;
                        state_reg    <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (cor_done) begin
                        unique case (sel_reg)
                            2'd0: begin
                                s1_reg    <= rot_s;
                                c1_reg    <= rot_c;
                                ang_reg   <= lat_reg;
                                sel_reg   <= 2'd1;
                                state_reg <= ST_RED;
                            end
                            2'd1: begin
                                s2_reg    <= rot_s;
                                c2_reg    <= rot_c;
                                ang_reg   <= first_lon_reg - lon_reg;
                                sel_reg   <= 2'd2;
                                state_reg <= ST_RED;
                            end
                            default: begin
                                cd_reg     <= rot_c;
                                mul_a_reg  <= absv(s1_reg);
                                mul_b_reg  <= absv(s2_reg);
                                pneg_reg   <= s1_reg[AW-1] ^ s2_reg[AW-1];
                                mul_go_reg <= 1'b1;
                                sel_reg    <= 2'd0;
                                state_reg  <= ST_MUL;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        unique case (sel_reg)
                            2'd0: begin
                                m1_reg     <= qres;
                                mul_a_reg  <= absv(c1_reg);
                                mul_b_reg  <= absv(c2_reg);
                                pneg_reg   <= c1_reg[AW-1] ^ c2_reg[AW-1];
                                mul_go_reg <= 1'b1;
                                sel_reg    <= 2'd1;
                            end
                            2'd1: begin
                                mul_a_reg  <= absv(qres);
                                mul_b_reg  <= absv(cd_reg);
                                pneg_reg   <= qres[AW-1] ^ cd_reg[AW-1];
                                mul_go_reg <= 1'b1;
                                sel_reg    <= 2'd2;
                            end
                            2'd2: begin
                                priority if (dot > gcd_pkg::ONE_Q) begin
                                    c_reg     <= gcd_pkg::ONE_Q;
                                    mul_a_reg <= absv(gcd_pkg::ONE_Q);
                                    mul_b_reg <= absv(gcd_pkg::ONE_Q);
                                end else if (dot < -gcd_pkg::ONE_Q) begin
                                    c_reg     <= -gcd_pkg::ONE_Q;
                                    mul_a_reg <= absv(gcd_pkg::ONE_Q);
                                    mul_b_reg <= absv(gcd_pkg::ONE_Q);
                                end else begin
                                    c_reg     <= dot;
                                    mul_a_reg <= absv(dot);
                                    mul_b_reg <= absv(dot);
                                end
                                pneg_reg   <= 1'b0;
                                mul_go_reg <= 1'b1;
                                sel_reg    <= 2'd3;
                            end
                            default: begin
                                rad_reg    <= 64'(gcd_pkg::ONE_Q - c2v) << AFB;
                                rem_reg    <= '0;
                                root_reg   <= '0;
                                sq_cnt_reg <= '0;
                                state_reg  <= ST_SQRT;
                            end
                        endcase
                    end
                end
                ST_SQRT: begin
                    rad_reg    <= {rad_reg[61:0], 2'b00};
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    if (sq_cnt_reg == 5'd31) begin
                        state_reg <= ST_VEC;
                        sel_reg   <= 2'd0;
                    end
                end
                ST_VEC: begin
                    if (sel_reg == 2'd0) begin
                        if (c_reg[AW-1]) begin
                            cor_x0_reg <= gcd_pkg::ang_t'({{(AW-32){1'b0}}, root_reg});
                            cor_y0_reg <= -c_reg;
                            cor_z0_reg <= gcd_pkg::HALF_PI_Q;
                        end else begin
                            cor_x0_reg <= c_reg;
                            cor_y0_reg <= gcd_pkg::ang_t'({{(AW-32){1'b0}}, root_reg});
                            cor_z0_reg <= '0;
                        end
                        cor_mode_reg <= gcd_pkg::MODE_VECTOR;
                        cor_go_reg   <= 1'b1;
                        sel_reg      <= 2'd1;
                    end else if (cor_done) begin
                        mul_a_reg  <= MW'(theta);
                        mul_b_reg  <= MW'(radius_reg);
                        pneg_reg   <= 1'b0;
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_RAD;
                    end
                end
                ST_RAD: begin
                    if (mul_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // product stays in the multiplier until the output slot frees up
                    if (!m_valid_reg || m_ready) begin
                        m_dist_reg <= rnd[AFB +: gcd_pkg::DIST_W];
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_distance_centi_km = m_dist_reg;
    assign pready              = 1'b1;
    assign prdata              = (paddr == 2'd0) ? 32'(radius_reg) : 32'd0;

endmodule
